// ----- rtl/core/wssa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssa_pkg
// Shared types and constants for the weighted splice sequence assigner.
// ----------------------------------------------------------------------------
package wssa_pkg;

  localparam int SPLICE_TOTAL_DEF = 64;
  localparam int NUM_SENDERS      = 4;
  localparam int RATIO_W          = 8;
  localparam int SEQ_W            = 32;
  localparam int SID_W            = 2;

  // configuration register indexes
  localparam logic CFG_SERVER_ID = 1'b0;
  localparam logic CFG_END_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    KIND_SKIP = 3'd0,
    KIND_DATA = 3'd1,
    KIND_FIN  = 3'd2,
    KIND_ACK  = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  typedef logic [NUM_SENDERS-1:0][RATIO_W-1:0] ratio_vec_t;

  typedef struct packed {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
  } result_t;

endpackage

// ----- rtl/core/wssa_slot_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssa_slot_engine
// Holds the ratio, bucket and sequence state and works out one slot or
// splice per accepted beat combinationally.
// ----------------------------------------------------------------------------
module wssa_slot_engine #(
  parameter int SPLICE_TOTAL = wssa_pkg::SPLICE_TOTAL_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [wssa_pkg::SEQ_W-1:0]    cfg_wdata,
  input  logic                          accept,
  input  logic                          cmd,
  input  wssa_pkg::ratio_vec_t          ratio_in,
  input  logic [wssa_pkg::SEQ_W-1:0]    start_seq,
  output wssa_pkg::result_t             res
);
  import wssa_pkg::*;

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'((SPLICE_TOTAL / 4) & 255);

  ratio_vec_t         active_r,  active_nxt;
  ratio_vec_t         pending_r, pending_nxt;
  ratio_vec_t         bucket_r,  bucket_nxt;
  logic [SEQ_W-1:0]   switch_seq_r, switch_seq_nxt;
  logic               switch_wait_r, switch_wait_nxt;
  logic [SEQ_W-1:0]   next_seq_r, next_seq_nxt;
  logic [SID_W-1:0]   server_id_r;
  logic [SEQ_W-1:0]   end_limit_r;

  ratio_vec_t             act_eff;
  ratio_vec_t             fill;
  logic [NUM_SENDERS-1:0] nz;
  logic                   sw_take;
  logic                   empty;
  logic [2:0]             n_taken;
  logic [2:0]             n_before;

  always_comb begin
    sw_take = switch_wait_r && (next_seq_r >= switch_seq_r);
    act_eff = sw_take ? pending_r : active_r;
    empty   = (bucket_r == '0);
    fill    = empty ? act_eff : bucket_r;
    n_taken  = '0;
    n_before = '0;
    for (int i = 0; i < NUM_SENDERS; i++) begin
      nz[i] = (fill[i] != '0);
      n_taken = n_taken + 3'(nz[i]);
      if (SID_W'(i) < server_id_r) begin
        n_before = n_before + 3'(nz[i]);
      end
    end
  end

  always_comb begin
    active_nxt      = active_r;
    pending_nxt     = pending_r;
    bucket_nxt      = bucket_r;
    switch_seq_nxt  = switch_seq_r;
    switch_wait_nxt = switch_wait_r;
    next_seq_nxt    = next_seq_r;
    res.kind        = KIND_SKIP;
    res.seq         = '0;
    if (cmd) begin
      pending_nxt     = ratio_in;
      switch_seq_nxt  = start_seq;
      switch_wait_nxt = 1'b1;
      res.kind        = (start_seq <= next_seq_r) ? KIND_ERR : KIND_ACK;
    end else if (next_seq_r > end_limit_r) begin
      res.kind = KIND_FIN;
    end else begin
      active_nxt = act_eff;
      if (sw_take) begin
        switch_wait_nxt = 1'b0;
      end
      for (int i = 0; i < NUM_SENDERS; i++) begin
        bucket_nxt[i] = fill[i] - RATIO_W'(nz[i]);
      end
      next_seq_nxt = next_seq_r + SEQ_W'(n_taken);
      if (nz[server_id_r]) begin
        res.kind = KIND_DATA;
        res.seq  = next_seq_r + SEQ_W'(n_before);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= {NUM_SENDERS{RATIO_RESET}};
      pending_r     <= '0;
      bucket_r      <= '0;
      switch_seq_r  <= '0;
      switch_wait_r <= 1'b0;
      next_seq_r    <= SEQ_W'(1);
      server_id_r   <= '0;
      end_limit_r   <= SEQ_W'(1000);
    end else begin
      if (accept) begin
        active_r      <= active_nxt;
        pending_r     <= pending_nxt;
        bucket_r      <= bucket_nxt;
        switch_seq_r  <= switch_seq_nxt;
        switch_wait_r <= switch_wait_nxt;
        next_seq_r    <= next_seq_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SERVER_ID: server_id_r <= cfg_wdata[SID_W-1:0];
          CFG_END_LIMIT: end_limit_r <= cfg_wdata;
          default:       ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/wssa_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssa_out_reg
// Result register with valid; frees itself on the same cycle it is taken.
// ----------------------------------------------------------------------------
module wssa_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  wssa_pkg::result_t  res_in,
  input  logic               take,
  output logic               ready,
  output logic               valid,
  output wssa_pkg::result_t  res_out
);
  import wssa_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign ready   = !valid_r || take;
  assign valid   = valid_r;
  assign res_out = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// ----- rtl/core/weighted_splice_sequence_assigner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_splice_sequence_assigner
// Weighted round robin sequence assignment for one of four striped senders,
// with splice commands that switch ratios at a chosen sequence number.
//
//   channel  dir  payload
//   in_      in   tuser: cmd; tdata: ratio_zero..ratio_three, start_seq
//   out_     out  tuser: pkt_kind; tdata: seq_out
//   cfg_     in   index 0 server_id, index 1 end_limit
//
// One beat per cycle while in_tready is high; each result is valid in the cycle
// after its input beat, set by the combinational state update ahead of the result register.
// in_tready drops only while a result is held and out_tready is low.
// Synchronous active-low reset restores ratios, buckets and next_seq = 1.
// ----------------------------------------------------------------------------
module weighted_splice_sequence_assigner #(
  parameter int SPLICE_TOTAL = wssa_pkg::SPLICE_TOTAL_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [wssa_pkg::SEQ_W-1:0]  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [0:0]                  in_tuser,   // [0] cmd
  // [7:0] ratio_zero, [15:8] ratio_one, [23:16] ratio_two,
  // [31:24] ratio_three, [63:32] start_seq
  input  logic [63:0]                 in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [2:0]                  out_tuser,  // [2:0] pkt_kind
  output logic [31:0]                 out_tdata   // [31:0] seq_out
);
  import wssa_pkg::*;

  logic       accept;
  result_t    res_c;
  result_t    res_q;
  ratio_vec_t ratio_in;

  assign accept   = in_tvalid && in_tready;
  assign ratio_in = in_tdata[31:0];

  wssa_slot_engine #(
    .SPLICE_TOTAL(SPLICE_TOTAL)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .cmd       (in_tuser[0]),
    .ratio_in  (ratio_in),
    .start_seq (in_tdata[63:32]),
    .res       (res_c)
  );

  wssa_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .res_in  (res_c),
    .take    (out_tready),
    .ready   (in_tready),
    .valid   (out_tvalid),
    .res_out (res_q)
  );

  assign out_tuser = res_q.kind;
  assign out_tdata = res_q.seq;

endmodule

// ----- tb/sv/tb_weighted_splice_sequence_assigner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_splice_sequence_assigner
// Self-checking bench for the weighted splice sequence assigner. A short
// directed table covers the reset shares, all-zero and full-scale splices,
// late and early start points and the ack/error split. Random phases then
// follow with varied sender ids and end limits, slot ticks mixed with
// splices, and random stalls on both streams. Every result beat is checked
// against a pin or a cycle-free model of share buckets and sequence counter.
// ----------------------------------------------------------------------------
module tb_weighted_splice_sequence_assigner;
  import wssa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [0:0]  in_tuser;   // [0] cmd
  // [7:0] ratio_zero, [15:8] ratio_one, [23:16] ratio_two,
  // [31:24] ratio_three, [63:32] start_seq
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [2:0]  out_tuser;  // [2:0] pkt_kind
  logic [31:0] out_tdata;  // [31:0] seq_out

  weighted_splice_sequence_assigner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // directed stimulus; shares packed with ratio_zero in the low byte
  typedef struct {
    bit          cmd;
    logic [31:0] shares;
    logic [31:0] start;
    bit          pinned;
    kind_t       kind;
    logic [31:0] seq;
  } plan_row_t;

  typedef struct {
    bit          pinned;
    kind_t       kind;
    logic [31:0] seq;
  } pin_t;

  localparam int PLAN_LEN = 16;
  plan_row_t plan [PLAN_LEN] = '{
    '{1'b1, 32'h00000000, 32'h00000000, 1'b1, KIND_ERR,  32'd0},
    '{1'b0, 32'h00000000, 32'h00000000, 1'b1, KIND_SKIP, 32'd0},  // all shares zero
    '{1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, KIND_SKIP, 32'd0},
    '{1'b1, 32'hFFFFFFFF, 32'h00000001, 1'b1, KIND_ERR,  32'd0},  // start equals seq
    '{1'b0, 32'h00000000, 32'h00000000, 1'b1, KIND_DATA, 32'd1},
    '{1'b1, 32'h04030201, 32'hFFFFFFFF, 1'b1, KIND_ACK,  32'd0},
    '{1'b0, 32'h00000000, 32'h00000000, 1'b1, KIND_DATA, 32'd5},
    '{1'b1, 32'h01000003, 32'h0000000A, 1'b1, KIND_ACK,  32'd0},  // replaces pending
    '{1'b0, 32'h00000000, 32'h00000000, 1'b1, KIND_DATA, 32'd9},
    '{1'b0, 32'h00000000, 32'h00000000, 1'b1, KIND_DATA, 32'd13},
    '{1'b1, 32'h00000000, 32'h80000000, 1'b0, KIND_SKIP, 32'd0},
    '{1'b0, 32'h00000000, 32'h00000000, 1'b0, KIND_SKIP, 32'd0},
    '{1'b1, 32'h02010003, 32'h00000000, 1'b0, KIND_SKIP, 32'd0},
    '{1'b0, 32'h00000000, 32'h00000000, 1'b0, KIND_SKIP, 32'd0},
    '{1'b0, 32'h00000000, 32'h00000000, 1'b0, KIND_SKIP, 32'd0},
    '{1'b0, 32'h00000000, 32'h00000000, 1'b0, KIND_SKIP, 32'd0}
  };

  // model state
  logic [7:0]  act_share  [4];
  logic [7:0]  pend_share [4];
  logic [7:0]  credit     [4];
  logic [31:0] switch_at;
  bit          switch_armed;
  logic [31:0] seq_next;
  logic [1:0]  my_sid;
  logic [31:0] seq_limit;

  result_t     result_q [$];
  pin_t        pin_q [$];
  int          errors;
  int          kind_cnt [5];
  int          slot_cnt;
  int          splice_cnt;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      act_share[i]  = 8'(SPLICE_TOTAL_DEF / 4);
      pend_share[i] = '0;
      credit[i]     = '0;
    end
    switch_at    = '0;
    switch_armed = 1'b0;
    seq_next     = 32'd1;
    my_sid       = '0;
    seq_limit    = 32'd1000;
  end

  task automatic predict_beat(input logic cmd, input logic [63:0] data,
                              output result_t res);
    logic [31:0] start;
    bit          drained;
    begin
      res.kind = KIND_SKIP;
      res.seq  = '0;
      if (cmd) begin
        start = data[63:32];
        for (int i = 0; i < 4; i++) pend_share[i] = data[8*i +: 8];
        switch_at    = start;
        switch_armed = 1'b1;
        res.kind     = (start <= seq_next) ? KIND_ERR : KIND_ACK;
      end else if (seq_next > seq_limit) begin
        res.kind = KIND_FIN;
      end else begin
        if (switch_armed && seq_next >= switch_at) begin
          act_share    = pend_share;
          switch_armed = 1'b0;
        end
        drained = 1'b1;
        for (int i = 0; i < 4; i++) if (credit[i] != 0) drained = 1'b0;
        if (drained) credit = act_share;
        // senders take numbers in order 0..3
        for (int i = 0; i < 4; i++) begin
          if (credit[i] != 0) begin
            credit[i] = credit[i] - 8'd1;
            if (i == my_sid) begin
              res.kind = KIND_DATA;
              res.seq  = seq_next;
            end
            seq_next = seq_next + 32'd1;
          end
        end
      end
    end
  endtask

  // input side: predict on every accepted beat, track register writes
  always @(posedge clk) begin
    result_t res;
    pin_t    pin;
    if (rst_n && cfg_wr_en) begin
      if (cfg_index == CFG_SERVER_ID) my_sid = cfg_wdata[1:0];
      else seq_limit = cfg_wdata;
    end
    if (rst_n && in_tvalid && in_tready) begin
      predict_beat(in_tuser[0], in_tdata, res);
      pin = pin_q.pop_front();
      if (pin.pinned) begin
        res.kind = pin.kind;
        res.seq  = pin.seq;
      end
      result_q.push_back(res);
    end
  end

  // output side
  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat kind %0d seq %0d", $time, out_tuser,
                 out_tdata);
      end else begin
        exp_res = result_q.pop_front();
        if (out_tuser !== exp_res.kind) begin
          errors++;
          $display("%0t: pkt_kind expected %0d actual %0d", $time, exp_res.kind,
                   out_tuser);
        end
        if (out_tdata !== exp_res.seq) begin
          errors++;
          $display("%0t: seq_out expected %0d actual %0d", $time, exp_res.seq,
                   out_tdata);
        end
        if (exp_res.kind <= KIND_ERR) kind_cnt[int'(exp_res.kind)]++;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  task automatic send_beat(input bit cmd, input logic [63:0] data, input pin_t pin);
    begin
      pin_q.push_back(pin);
      if (cmd) splice_cnt++;
      else slot_cnt++;
      in_tuser  <= cmd;
      in_tdata  <= data;
      in_tvalid <= 1'b1;
      do @(posedge clk); while (!in_tready);
      if (!calm && $urandom_range(0, 99) < 20) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  endtask

  // hold the sender until every result is back, then leave the block idle
  task automatic drain_results();
    begin
      in_tvalid <= 1'b0;
      repeat (2) @(posedge clk);
      while (result_q.size() != 0) @(posedge clk);
      repeat (3) @(posedge clk);
    end
  endtask

  // one write per call, with write enable dropped again after it
  task automatic write_reg(input logic idx, input logic [31:0] val);
    begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= val;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    pin_t        pin;
    logic [31:0] shares;
    logic [31:0] start;
    logic [31:0] limit;
    int          pick;
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = CFG_SERVER_ID;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tuser   = '0;
    in_tdata   = '0;
    calm       = 1'b0;
    errors     = 0;
    slot_cnt   = 0;
    splice_cnt = 0;
    for (int k = 0; k < 5; k++) kind_cnt[k] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs on the reset register values
    for (int r = 0; r < PLAN_LEN; r++) begin
      pin.pinned = plan[r].pinned;
      pin.kind   = plan[r].kind;
      pin.seq    = plan[r].seq;
      send_beat(plan[r].cmd, {plan[r].start, plan[r].shares}, pin);
    end

    pin.pinned = 1'b0;
    pin.kind   = KIND_SKIP;
    pin.seq    = '0;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0:       limit = 32'd0;
        1:       limit = $urandom;
        7:       limit = 32'hFFFFFFFF;
        default: limit = seq_next + $urandom_range(10, 200);
      endcase
      write_reg(CFG_SERVER_ID, (ph < 4) ? 32'(ph) : 32'($urandom_range(0, 3)));
      write_reg(CFG_END_LIMIT, limit);
      calm = (ph == 4);
      for (int n = 0; n < 88; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) shares = '0;
          else if (pick == 1) shares = $urandom;
          else shares = {8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)),
                         8'($urandom_range(0, 5)), 8'($urandom_range(0, 5))};
          pick = $urandom_range(0, 9);
          // mostly near the running sequence, so both ack and error occur
          if (pick < 4) start = seq_next + $urandom_range(1, 30);
          else if (pick < 7) start = seq_next - $urandom_range(0, 3);
          else if (pick == 7) start = $urandom;
          else if (pick == 8) start = '0;
          else start = 32'hFFFFFFFF;
          send_beat(1'b1, {start, shares}, pin);
        end else begin
          send_beat(1'b0, {$urandom, $urandom}, pin);
        end
      end
    end
    calm = 1'b0;
    drain_results();

    $display("Covered %0d slot ticks and %0d splices over 8 register settings.",
             slot_cnt, splice_cnt);
    $display("Results: data %0d, skip %0d, finish %0d, ack %0d, error %0d.",
             kind_cnt[KIND_DATA], kind_cnt[KIND_SKIP], kind_cnt[KIND_FIN],
             kind_cnt[KIND_ACK], kind_cnt[KIND_ERR]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/wssa_pkg.sv
rtl/core/wssa_slot_engine.sv
rtl/core/wssa_out_reg.sv
rtl/core/weighted_splice_sequence_assigner.sv
tb/sv/tb_weighted_splice_sequence_assigner.sv
